@@ rtl/core/qpack_dynamic_table_bookkeeping_assert.svh @@
// Assertion macros used by the table bookkeeping checker.
`ifndef QPACK_DYNAMIC_TABLE_BOOKKEEPING_ASSERT_SVH
`define QPACK_DYNAMIC_TABLE_BOOKKEEPING_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define QDT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qdt assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define QDT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qdt assertion failed");

`endif

@@ rtl/core/qdt_pkg.sv @@
// Shared constants, codes and helpers of the dynamic table bookkeeping block.
package qdt_pkg;

    localparam int RING_DEPTH     = 1024;
    localparam int SLOT_W         = $clog2(RING_DEPTH);
    localparam int CNT_W          = $clog2(RING_DEPTH + 1);
    localparam int SUM_W          = CNT_W + 1;
    localparam int LEN_W          = 16;
    localparam int ENTRY_OVERHEAD = 32;
    localparam int STATIC_ENTRIES = 99;
    localparam int LIMIT_W        = 15;
    localparam int MAXENT_W       = LIMIT_W - 5;
    localparam int RANGE_W        = MAXENT_W + 1;
    localparam int DVD_W          = 33;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd16384;

    // Commands.
    localparam logic [2:0] CMD_SET_CAP  = 3'd0;
    localparam logic [2:0] CMD_NAME_REF = 3'd1;
    localparam logic [2:0] CMD_LITERAL  = 3'd2;
    localparam logic [2:0] CMD_DUP      = 3'd3;
    localparam logic [2:0] CMD_DECODE   = 3'd4;
    localparam logic [2:0] CMD_ACK      = 3'd5;
    localparam logic [2:0] CMD_FLUSH    = 3'd6;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ENC_ERR  = 2'd1;
    localparam logic [1:0] ST_DEC_FAIL = 2'd2;
    localparam logic [1:0] ST_BLOCKED  = 2'd3;

    // Name lengths of the static table.
    localparam logic [5:0] STATIC_NAME_LEN [STATIC_ENTRIES] = '{
        6'd10, 6'd5, 6'd3, 6'd19, 6'd14, 6'd6, 6'd4, 6'd4, 6'd17, 6'd13,
        6'd13, 6'd4, 6'd8, 6'd7, 6'd10, 6'd7, 6'd7, 6'd7, 6'd7, 6'd7,
        6'd7, 6'd7, 6'd7, 6'd7, 6'd7, 6'd7, 6'd7, 6'd7, 6'd7, 6'd6,
        6'd6, 6'd15, 6'd13, 6'd28, 6'd28, 6'd27, 6'd13, 6'd13, 6'd13, 6'd13,
        6'd13, 6'd13, 6'd16, 6'd16, 6'd12, 6'd12, 6'd12, 6'd12, 6'd12, 6'd12,
        6'd12, 6'd12, 6'd12, 6'd12, 6'd12, 6'd5, 6'd25, 6'd25, 6'd25, 6'd4,
        6'd4, 6'd22, 6'd16, 6'd7, 6'd7, 6'd7, 6'd7, 6'd7, 6'd7, 6'd7,
        6'd7, 6'd7, 6'd15, 6'd32, 6'd32, 6'd28, 6'd28, 6'd28, 6'd28, 6'd29,
        6'd30, 6'd29, 6'd29, 6'd7, 6'd13, 6'd23, 6'd10, 6'd9, 6'd9, 6'd8,
        6'd6, 6'd7, 6'd6, 6'd19, 6'd25, 6'd10, 6'd15, 6'd15, 6'd15
    };

    // Ring slot a given number of entries after a base slot; the offset used
    // never exceeds the ring depth, so one conditional subtract wraps it.
    function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] base,
                                                   input logic [CNT_W-1:0] offs);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(offs);
        if (sum >= SUM_W'(RING_DEPTH)) begin
            sum = sum - SUM_W'(RING_DEPTH);
        end
        return sum[SLOT_W-1:0];
    endfunction

endpackage

@@ rtl/core/qdt_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module qdt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/qdt_rem.sv @@
// Bit-serial remainder unit: dividend modulo divisor, one dividend bit per cycle.
module qdt_rem (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [qdt_pkg::DVD_W-1:0]   i_dividend,
    input  logic [qdt_pkg::RANGE_W-1:0] i_divisor,
    output logic                        o_done,
    output logic [qdt_pkg::RANGE_W-1:0] o_rem
);

    localparam int CNT_BITS = $clog2(qdt_pkg::DVD_W + 1);

    logic [qdt_pkg::DVD_W-1:0]   r_dvd;
    logic [qdt_pkg::RANGE_W-1:0] r_div;
    logic [qdt_pkg::RANGE_W-1:0] r_rem;
    logic [CNT_BITS-1:0]         r_cnt;
    logic                        r_busy;
    logic                        r_done;
    logic [qdt_pkg::RANGE_W:0]   shifted;
    logic [qdt_pkg::RANGE_W:0]   n_rem;

    // One restoring step: bring in the next dividend bit, subtract if it fits.
    always_comb begin
        shifted = {r_rem, r_dvd[qdt_pkg::DVD_W-1]};
        if (shifted >= {1'b0, r_div}) begin
            n_rem = shifted - {1'b0, r_div};
        end else begin
            n_rem = shifted;
        end
    end

    // Step sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_dvd  <= i_dividend;
                r_div  <= i_divisor;
                r_rem  <= '0;
                r_cnt  <= CNT_BITS'(qdt_pkg::DVD_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= n_rem[qdt_pkg::RANGE_W-1:0];
                r_dvd <= {r_dvd[qdt_pkg::DVD_W-2:0], 1'b0};
                r_cnt <= r_cnt - CNT_BITS'(1);
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

@@ rtl/core/qpack_dynamic_table_bookkeeping.sv @@
// Top level of the header-compression dynamic table bookkeeping block.
//
// Commands enter on the input channel (i_valid, o_stall) and one result per
// command leaves on the output channel (o_valid, i_stall). A transfer happens
// at a clock edge with valid high and stall low. The block works on one
// command at a time and raises o_stall from the transfer until its result
// sits in the output register, and while reset is held.
// Ack, flush, unused codes and errors found up front go from decode straight
// to the output stage. Set capacity then checks whether the table must
// shrink. A literal or static entry that is too large fails the size check;
// a literal or static insert passes it and writes the ring, a dynamic
// reference or duplicate first reads the referenced entry, and every evicted
// entry takes one ring read. A required-count decode waits on the bit-serial
// remainder unit (33 steps), then unwraps the count around its remainder.
// A finished result waits in the output register while i_stall is high; the
// next command is already taken meanwhile and finishes into that register
// once it is free. The single configuration register (table limit) is
// written through i_cfg_valid/o_cfg_ready, which is ready outside reset.
// Synchronous reset empties the table, zeroes capacity and acknowledged
// count and sets the limit to 16384; ring contents are not cleared.
module qpack_dynamic_table_bookkeeping (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [2:0]                    i_command,
    input  logic                          i_ref_dynamic,
    input  logic [15:0]                   i_index,
    input  logic [15:0]                   i_name_len,
    input  logic [15:0]                   i_value_len,
    input  logic [15:0]                   i_new_capacity,
    input  logic [15:0]                   i_encoded_count,
    input  logic [31:0]                   i_ack_count,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [qdt_pkg::LIMIT_W-1:0]   i_cfg_data,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [1:0]                    o_status,
    output logic [31:0]                   o_abs_index,
    output logic [qdt_pkg::SLOT_W-1:0]    o_source_slot,
    output logic [qdt_pkg::SLOT_W-1:0]    o_new_slot,
    output logic [qdt_pkg::CNT_W-1:0]     o_evicted,
    output logic [31:0]                   o_required_count,
    output logic [31:0]                   o_increment,
    output logic [31:0]                   o_total_inserted,
    output logic [15:0]                   o_used_size
);

    localparam int SLOT_W   = qdt_pkg::SLOT_W;
    localparam int CNT_W    = qdt_pkg::CNT_W;
    localparam int LEN_W    = qdt_pkg::LEN_W;
    localparam int RANGE_W  = qdt_pkg::RANGE_W;
    localparam int MAXENT_W = qdt_pkg::MAXENT_W;
    localparam int DVD_W    = qdt_pkg::DVD_W;
    localparam int REQ_W    = DVD_W + 2;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_REF_RD, S_REF_DATA, S_ADD, S_DROP_RD, S_DROP_DATA,
        S_WRITE, S_SHRINK, S_DIV, S_REQ, S_REQ_CHK, S_OUT
    } t_state;

    t_state r_state;

    // Latched command.
    logic [2:0]   r_cmd;
    logic         r_dyn;
    logic [15:0]  r_index;
    logic [15:0]  r_name_in;
    logic [15:0]  r_value_in;
    logic [15:0]  r_new_cap;
    logic [15:0]  r_enc;
    logic [31:0]  r_ack;

    // Table state.
    logic [qdt_pkg::LIMIT_W-1:0] r_limit;
    logic [SLOT_W-1:0]           r_oldest_slot;
    logic [31:0]                 r_oldest_index;
    logic [CNT_W-1:0]            r_count;
    logic [16:0]                 r_size;
    logic [15:0]                 r_cap;
    logic [31:0]                 r_acked;

    // Working registers.
    logic [LEN_W-1:0]  r_nl;
    logic [LEN_W-1:0]  r_vl;
    logic [SLOT_W-1:0] r_src;
    logic              r_pre;
    logic [DVD_W-1:0]  r_maxval;
    logic [REQ_W-1:0]  r_req;

    // Result being built.
    logic [1:0]        r_res_status;
    logic [31:0]       r_res_abs;
    logic [SLOT_W-1:0] r_res_src;
    logic [SLOT_W-1:0] r_res_new;
    logic [CNT_W-1:0]  r_res_ev;
    logic [31:0]       r_res_req;
    logic [31:0]       r_res_inc;

    // Output register.
    logic              r_o_valid;
    logic [1:0]        r_o_status;
    logic [31:0]       r_o_abs;
    logic [SLOT_W-1:0] r_o_src;
    logic [SLOT_W-1:0] r_o_new;
    logic [CNT_W-1:0]  r_o_ev;
    logic [31:0]       r_o_req;
    logic [31:0]       r_o_inc;
    logic [31:0]       r_o_total;
    logic [15:0]       r_o_used;

    logic [31:0]             total;
    logic [CNT_W-1:0]        ref_off;
    logic [SLOT_W-1:0]       ref_slot;
    logic [SLOT_W-1:0]       wr_slot;
    logic [SLOT_W-1:0]       next_oldest;
    logic [17:0]             entry_size;
    logic [17:0]             drop_size;
    logic [MAXENT_W-1:0]     entry_limit;
    logic [RANGE_W-1:0]      wrap_span;
    logic [DVD_W-1:0]        maxval_c;
    logic [2*LEN_W-1:0]      rd_data;
    logic [SLOT_W-1:0]       rd_addr;
    logic                    wr_en;
    logic                    div_start;
    logic                    div_done;
    logic [RANGE_W-1:0]      div_rem;
    logic                    in_xfer;

    // Derived counts and ring positions.
    assign total       = r_oldest_index + 32'(r_count);
    assign ref_off     = r_count - CNT_W'(1) - CNT_W'(r_index);
    assign ref_slot    = qdt_pkg::slot_add(r_oldest_slot, ref_off);
    assign wr_slot     = qdt_pkg::slot_add(r_oldest_slot, r_count);
    assign next_oldest = qdt_pkg::slot_add(r_oldest_slot, CNT_W'(1));
    assign entry_size  = 18'(r_nl) + 18'(r_vl) + 18'(qdt_pkg::ENTRY_OVERHEAD);
    assign drop_size   = 18'(rd_data[2*LEN_W-1:LEN_W]) + 18'(rd_data[LEN_W-1:0])
                       + 18'(qdt_pkg::ENTRY_OVERHEAD);
    assign entry_limit = r_limit[qdt_pkg::LIMIT_W-1:5];
    assign wrap_span   = {entry_limit, 1'b0};
    assign maxval_c    = DVD_W'(total) + DVD_W'(entry_limit);

    // Ring memory of name and value lengths.
    assign rd_addr   = (r_state == S_REF_RD) ? ref_slot : r_oldest_slot;
    assign wr_en     = (r_state == S_WRITE);
    assign div_start = (r_state == S_DECODE) && (r_cmd == qdt_pkg::CMD_DECODE)
                     && (r_enc != 16'd0) && (17'(r_enc) <= 17'(wrap_span));

    qdt_ram #(
        .WIDTH (2 * LEN_W),
        .DEPTH (qdt_pkg::RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_slot),
        .i_wdata ({r_nl, r_vl}),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    qdt_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (maxval_c),
        .i_divisor  (wrap_span),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    assign in_xfer = i_valid && !o_stall;

    // Command sequencer, table state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_o_valid      <= 1'b0;
            r_limit        <= qdt_pkg::LIMIT_RESET;
            r_oldest_slot  <= '0;
            r_oldest_index <= '0;
            r_count        <= '0;
            r_size         <= '0;
            r_cap          <= '0;
            r_acked        <= '0;
            r_pre          <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
            if (r_o_valid && !i_stall && r_state != S_OUT) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_cmd        <= i_command;
                        r_dyn        <= i_ref_dynamic;
                        r_index      <= i_index;
                        r_name_in    <= i_name_len;
                        r_value_in   <= i_value_len;
                        r_new_cap    <= i_new_capacity;
                        r_enc        <= i_encoded_count;
                        r_ack        <= i_ack_count;
                        r_res_status <= qdt_pkg::ST_OK;
                        r_res_abs    <= '0;
                        r_res_src    <= '0;
                        r_res_new    <= '0;
                        r_res_ev     <= '0;
                        r_res_req    <= '0;
                        r_res_inc    <= '0;
                        r_state      <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    r_vl <= r_value_in;
                    case (r_cmd)
                        qdt_pkg::CMD_SET_CAP: begin
                            if (r_new_cap > 16'(r_limit)) begin
                                r_res_status <= qdt_pkg::ST_ENC_ERR;
                                r_state      <= S_OUT;
                            end else begin
                                r_cap   <= r_new_cap;
                                r_state <= S_SHRINK;
                            end
                        end
                        qdt_pkg::CMD_NAME_REF: begin
                            if (r_dyn) begin
                                if (32'(r_index) >= 32'(r_count)) begin
                                    r_res_status <= qdt_pkg::ST_ENC_ERR;
                                    r_state      <= S_OUT;
                                end else begin
                                    r_state <= S_REF_RD;
                                end
                            end else if (r_index >= 16'(qdt_pkg::STATIC_ENTRIES)) begin
                                r_res_status <= qdt_pkg::ST_ENC_ERR;
                                r_state      <= S_OUT;
                            end else begin
                                r_nl    <= LEN_W'(qdt_pkg::STATIC_NAME_LEN[r_index[6:0]]);
                                r_state <= S_ADD;
                            end
                        end
                        qdt_pkg::CMD_LITERAL: begin
                            r_nl    <= r_name_in;
                            r_state <= S_ADD;
                        end
                        qdt_pkg::CMD_DUP: begin
                            if (32'(r_index) >= 32'(r_count)) begin
                                r_res_status <= qdt_pkg::ST_ENC_ERR;
                                r_state      <= S_OUT;
                            end else begin
                                r_state <= S_REF_RD;
                            end
                        end
                        qdt_pkg::CMD_DECODE: begin
                            if (r_enc == 16'd0) begin
                                r_state <= S_OUT;
                            end else if (17'(r_enc) > 17'(wrap_span)) begin
                                r_res_status <= qdt_pkg::ST_DEC_FAIL;
                                r_state      <= S_OUT;
                            end else begin
                                r_maxval <= maxval_c;
                                r_state  <= S_DIV;
                            end
                        end
                        qdt_pkg::CMD_ACK: begin
                            if (r_acked < r_ack) begin
                                r_acked <= r_ack;
                            end
                            r_state <= S_OUT;
                        end
                        qdt_pkg::CMD_FLUSH: begin
                            if (total > r_acked) begin
                                r_res_inc <= total - r_acked;
                                r_acked   <= total;
                            end
                            r_state <= S_OUT;
                        end
                        default: begin
                            r_state <= S_OUT;
                        end
                    endcase
                end
                // Read the referenced dynamic entry.
                S_REF_RD: begin
                    r_src   <= ref_slot;
                    r_state <= S_REF_DATA;
                end
                S_REF_DATA: begin
                    r_nl <= rd_data[2*LEN_W-1:LEN_W];
                    if (r_cmd == qdt_pkg::CMD_DUP) begin
                        r_vl <= rd_data[LEN_W-1:0];
                    end
                    r_state <= S_ADD;
                end
                // Size check, and room in the ring.
                S_ADD: begin
                    if (entry_size > 18'(r_cap)) begin
                        r_res_status <= qdt_pkg::ST_ENC_ERR;
                        r_state      <= S_OUT;
                    end else if (32'(r_count) >= 32'(qdt_pkg::RING_DEPTH)) begin
                        r_pre   <= 1'b1;
                        r_state <= S_DROP_RD;
                    end else begin
                        r_state <= S_WRITE;
                    end
                end
                S_DROP_RD: begin
                    r_state <= S_DROP_DATA;
                end
                // Retire the oldest entry.
                S_DROP_DATA: begin
                    if (18'(r_size) >= drop_size) begin
                        r_size <= r_size - drop_size[16:0];
                    end else begin
                        r_size <= '0;
                    end
                    r_oldest_slot  <= next_oldest;
                    r_oldest_index <= r_oldest_index + 32'd1;
                    r_count        <= r_count - CNT_W'(1);
                    r_res_ev       <= r_res_ev + CNT_W'(1);
                    if (r_pre) begin
                        r_pre   <= 1'b0;
                        r_state <= S_WRITE;
                    end else begin
                        r_state <= S_SHRINK;
                    end
                end
                // Store the new entry at the tail of the ring.
                S_WRITE: begin
                    r_res_abs <= total;
                    r_res_new <= wr_slot;
                    if (r_cmd == qdt_pkg::CMD_DUP
                            || (r_cmd == qdt_pkg::CMD_NAME_REF && r_dyn)) begin
                        r_res_src <= r_src;
                    end
                    r_count <= r_count + CNT_W'(1);
                    r_size  <= r_size + entry_size[16:0];
                    r_state <= S_SHRINK;
                end
                S_SHRINK: begin
                    if (r_size > 17'(r_cap) && r_count != '0) begin
                        r_state <= S_DROP_RD;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                // Unwrap the required count around the remainder.
                S_DIV: begin
                    if (div_done) begin
                        r_req   <= REQ_W'(r_maxval) - REQ_W'(div_rem)
                                 + REQ_W'(r_enc) - REQ_W'(1);
                        r_state <= S_REQ;
                    end
                end
                S_REQ: begin
                    if (r_req > REQ_W'(r_maxval) && r_req <= REQ_W'(wrap_span)) begin
                        r_res_status <= qdt_pkg::ST_DEC_FAIL;
                        r_state      <= S_OUT;
                    end else begin
                        if (r_req > REQ_W'(r_maxval)) begin
                            r_req <= r_req - REQ_W'(wrap_span);
                        end
                        r_state <= S_REQ_CHK;
                    end
                end
                S_REQ_CHK: begin
                    if (r_req == '0) begin
                        r_res_status <= qdt_pkg::ST_DEC_FAIL;
                    end else begin
                        r_res_req <= r_req[31:0];
                        if (r_req[31:0] > total) begin
                            r_res_status <= qdt_pkg::ST_BLOCKED;
                        end
                    end
                    r_state <= S_OUT;
                end
                // Hand the result to the output register once it is free.
                S_OUT: begin
                    if (!r_o_valid || !i_stall) begin
                        r_o_valid  <= 1'b1;
                        r_o_status <= r_res_status;
                        r_o_abs    <= r_res_abs;
                        r_o_src    <= r_res_src;
                        r_o_new    <= r_res_new;
                        r_o_ev     <= r_res_ev;
                        r_o_req    <= r_res_req;
                        r_o_inc    <= r_res_inc;
                        r_o_total  <= total;
                        r_o_used   <= r_size[15:0];
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall          = (r_state != S_IDLE) || !i_rst_n;
    assign o_cfg_ready      = i_rst_n;
    assign o_valid          = r_o_valid;
    assign o_status         = r_o_status;
    assign o_abs_index      = r_o_abs;
    assign o_source_slot    = r_o_src;
    assign o_new_slot       = r_o_new;
    assign o_evicted        = r_o_ev;
    assign o_required_count = r_o_req;
    assign o_increment      = r_o_inc;
    assign o_total_inserted = r_o_total;
    assign o_used_size      = r_o_used;

endmodule

@@ rtl/core/qdt_checker.sv @@
// Port-level checker for the table bookkeeping block, bound to the top level.
`include "qpack_dynamic_table_bookkeeping_assert.svh"

module qdt_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       o_stall,
    input logic                       o_valid,
    input logic                       i_stall,
    input logic [1:0]                 o_status,
    input logic [31:0]                o_abs_index,
    input logic [qdt_pkg::SLOT_W-1:0] o_source_slot,
    input logic [qdt_pkg::SLOT_W-1:0] o_new_slot,
    input logic [qdt_pkg::CNT_W-1:0]  o_evicted,
    input logic [31:0]                o_required_count,
    input logic [31:0]                o_total_inserted
);

    logic stalled;
    logic taken;
    logic failed;
    logic clean;
    logic blocked;

    // Conditions watched by the assertions below.
    assign stalled = o_valid && i_stall;
    assign taken   = i_valid && !o_stall;
    assign failed  = o_valid && (o_status == qdt_pkg::ST_ENC_ERR
                               || o_status == qdt_pkg::ST_DEC_FAIL);
    assign clean   = o_abs_index == 32'd0 && o_new_slot == '0 && o_source_slot == '0
                   && o_evicted == '0 && o_required_count == 32'd0;
    assign blocked = o_valid && o_status == qdt_pkg::ST_BLOCKED;

    // A stalled result stays offered, with its status and insert total unchanged.
    `QDT_ASSERT_NEXT(a_hold_valid, i_clk, i_rst_n, stalled, o_valid)
    `QDT_ASSERT_NEXT(a_hold_data, i_clk, i_rst_n, stalled, $stable({o_status, o_total_inserted}))

    // One command at a time: once a command has transferred, the input is closed.
    `QDT_ASSERT_NEXT(a_one_cmd, i_clk, i_rst_n, taken, o_stall)

    // Failed commands report no entry and no eviction.
    `QDT_ASSERT_SAME(a_err_clean, i_clk, i_rst_n, failed, clean)

    // A blocked decode asks for more inserts than have happened.
    `QDT_ASSERT_SAME(a_blocked, i_clk, i_rst_n, blocked, o_required_count > o_total_inserted)

endmodule

bind qpack_dynamic_table_bookkeeping qdt_checker u_qdt_checker (.*);

@@ tb/sv/qpack_dynamic_table_bookkeeping_test.sv @@
// Self-checking testbench for the dynamic table bookkeeping block.
module qpack_dynamic_table_bookkeeping_test;
    timeunit 1ns;
    timeprecision 1ps;

    import qdt_pkg::*;

    typedef struct {
        logic [2:0]  command;
        logic        ref_dynamic;
        logic [15:0] index;
        logic [15:0] name_len;
        logic [15:0] value_len;
        logic [15:0] new_capacity;
        logic [15:0] encoded_count;
        logic [31:0] ack_count;
    } t_table_cmd;

    typedef struct {
        logic [1:0]        status;
        logic [31:0]       abs_index;
        logic [SLOT_W-1:0] source_slot;
        logic [SLOT_W-1:0] new_slot;
        logic [CNT_W-1:0]  evicted;
        logic [31:0]       required_count;
        logic [31:0]       increment;
        logic [31:0]       total_inserted;
        logic [15:0]       used_size;
    } t_table_result;

    // Shadow copy of the table bookkeeping and the queue of outcomes it predicts.
    class t_table_tracker;
        logic [15:0]   name_ring [RING_DEPTH];
        logic [15:0]   value_ring [RING_DEPTH];
        int unsigned   oldest_slot;
        int unsigned   oldest_index;
        int unsigned   entry_count;
        int unsigned   table_size;
        int unsigned   capacity;
        int unsigned   acked;
        int unsigned   limit;
        int            errors;
        t_table_result pending_results [$];

        function new();
            oldest_slot = 0;
            oldest_index = 0;
            entry_count = 0;
            table_size = 0;
            capacity = 0;
            acked = 0;
            limit = LIMIT_RESET;
            errors = 0;
        endfunction

        function int unsigned inserts_total();
            return oldest_index + entry_count;
        endfunction

        function void drop_oldest();
            int unsigned sz;
            sz = name_ring[oldest_slot] + value_ring[oldest_slot] + ENTRY_OVERHEAD;
            table_size = (table_size >= sz) ? table_size - sz : 0;
            oldest_slot = (oldest_slot + 1) % RING_DEPTH;
            oldest_index++;
            entry_count--;
        endfunction

        function int unsigned shrink_to(int unsigned target);
            int unsigned n;
            n = 0;
            while (table_size > target && entry_count > 0) begin
                drop_oldest();
                n++;
            end
            return n;
        endfunction

        // Appends one entry; returns its status and fills the index, new slot and eviction fields on success.
        function logic [1:0] append_entry(int unsigned nl, int unsigned vl,
                                          inout t_table_result r);
            int unsigned sz;
            int unsigned ev;
            int unsigned s;
            sz = nl + vl + ENTRY_OVERHEAD;
            ev = 0;
            if (sz > capacity) begin
                return ST_ENC_ERR;
            end
            if (entry_count >= RING_DEPTH) begin
                drop_oldest();
                ev++;
            end
            s = (oldest_slot + entry_count) % RING_DEPTH;
            name_ring[s] = nl[15:0];
            value_ring[s] = vl[15:0];
            r.abs_index = inserts_total();
            r.new_slot = s[SLOT_W-1:0];
            entry_count++;
            table_size += sz;
            ev += shrink_to(capacity);
            r.evicted = ev[CNT_W-1:0];
            return ST_OK;
        endfunction

        // Works out the outcome of one accepted command and queues it.
        function void note_command(t_table_cmd c);
            t_table_result r;
            logic [1:0] st;
            int unsigned s;
            longint unsigned max_ent, span, top_value, req;
            r = '{default: '0};
            st = ST_OK;
            case (c.command)
                CMD_SET_CAP: begin
                    if (c.new_capacity > limit) begin
                        st = ST_ENC_ERR;
                    end else begin
                        r.evicted = CNT_W'(shrink_to(c.new_capacity));
                        capacity = c.new_capacity;
                    end
                end
                CMD_NAME_REF: begin
                    if (c.ref_dynamic) begin
                        if (c.index >= entry_count) begin
                            st = ST_ENC_ERR;
                        end else begin
                            s = (oldest_slot + entry_count - 1 - c.index) % RING_DEPTH;
                            st = append_entry(name_ring[s], c.value_len, r);
                            if (st == ST_OK) r.source_slot = s[SLOT_W-1:0];
                        end
                    end else if (c.index >= STATIC_ENTRIES) begin
                        st = ST_ENC_ERR;
                    end else begin
                        st = append_entry(STATIC_NAME_LEN[c.index], c.value_len, r);
                    end
                end
                CMD_LITERAL: begin
                    st = append_entry(c.name_len, c.value_len, r);
                end
                CMD_DUP: begin
                    if (c.index >= entry_count) begin
                        st = ST_ENC_ERR;
                    end else begin
                        s = (oldest_slot + entry_count - 1 - c.index) % RING_DEPTH;
                        st = append_entry(name_ring[s], value_ring[s], r);
                        if (st == ST_OK) r.source_slot = s[SLOT_W-1:0];
                    end
                end
                CMD_DECODE: begin
                    if (c.encoded_count != 0) begin
                        max_ent = limit / ENTRY_OVERHEAD;
                        span = 2 * max_ent;
                        if (c.encoded_count > span) begin
                            st = ST_DEC_FAIL;
                        end else begin
                            top_value = longint'(inserts_total()) + max_ent;
                            req = (top_value / span) * span + c.encoded_count - 1;
                            if (req > top_value) begin
                                if (req <= span) st = ST_DEC_FAIL;
                                else req -= span;
                            end
                            if (st == ST_OK && req == 0) st = ST_DEC_FAIL;
                            if (st == ST_OK) begin
                                r.required_count = req[31:0];
                                if (req[31:0] > inserts_total()) st = ST_BLOCKED;
                            end
                        end
                    end
                end
                CMD_ACK: begin
                    if (acked < c.ack_count) acked = c.ack_count;
                end
                CMD_FLUSH: begin
                    if (inserts_total() > acked) begin
                        r.increment = inserts_total() - acked;
                        acked = inserts_total();
                    end
                end
                default: ;
            endcase
            if (st != ST_OK) begin
                r.abs_index = '0;
                r.source_slot = '0;
                r.new_slot = '0;
                r.evicted = '0;
                if (st != ST_BLOCKED) r.required_count = '0;
            end
            r.status = st;
            r.total_inserted = inserts_total();
            r.used_size = table_size[15:0];
            pending_results.push_back(r);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("%0t: %s is %0d, expected %0d", $realtime, what, got, want);
            errors++;
        endtask

        task check_result(t_table_result g);
            t_table_result w;
            if (pending_results.size() == 0) begin
                report("unexpected result, status", g.status, 0);
                return;
            end
            w = pending_results.pop_front();
            if (g.status !== w.status) report("status", g.status, w.status);
            if (g.abs_index !== w.abs_index) report("abs_index", g.abs_index, w.abs_index);
            if (g.source_slot !== w.source_slot)
                report("source_slot", g.source_slot, w.source_slot);
            if (g.new_slot !== w.new_slot) report("new_slot", g.new_slot, w.new_slot);
            if (g.evicted !== w.evicted) report("evicted", g.evicted, w.evicted);
            if (g.required_count !== w.required_count)
                report("required_count", g.required_count, w.required_count);
            if (g.increment !== w.increment) report("increment", g.increment, w.increment);
            if (g.total_inserted !== w.total_inserted)
                report("total_inserted", g.total_inserted, w.total_inserted);
            if (g.used_size !== w.used_size) report("used_size", g.used_size, w.used_size);
        endtask
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [2:0]        i_command;
    logic              i_ref_dynamic;
    logic [15:0]       i_index;
    logic [15:0]       i_name_len;
    logic [15:0]       i_value_len;
    logic [15:0]       i_new_capacity;
    logic [15:0]       i_encoded_count;
    logic [31:0]       i_ack_count;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [LIMIT_W-1:0] i_cfg_data;
    logic              o_valid;
    logic              i_stall;
    logic [1:0]        o_status;
    logic [31:0]       o_abs_index;
    logic [SLOT_W-1:0] o_source_slot;
    logic [SLOT_W-1:0] o_new_slot;
    logic [CNT_W-1:0]  o_evicted;
    logic [31:0]       o_required_count;
    logic [31:0]       o_increment;
    logic [31:0]       o_total_inserted;
    logic [15:0]       o_used_size;

    t_table_tracker tracker;
    int max_gap;

    qpack_dynamic_table_bookkeeping uut (.*);

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Sends one command after a random gap and waits for its transfer.
    task send_command(t_table_cmd c);
        int gap;
        gap = $urandom_range(0, max_gap);
        repeat (gap) begin
            @(negedge i_clk);
            i_valid = 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        i_command = c.command;
        i_ref_dynamic = c.ref_dynamic;
        i_index = c.index;
        i_name_len = c.name_len;
        i_value_len = c.value_len;
        i_new_capacity = c.new_capacity;
        i_encoded_count = c.encoded_count;
        i_ack_count = c.ack_count;
        i_valid = 1'b1;
        do @(posedge i_clk); while (o_stall);
        tracker.note_command(c);
    endtask

    // Writes the table limit once every outstanding result has come back.
    task write_limit(logic [LIMIT_W-1:0] v);
        @(negedge i_clk);
        i_valid = 1'b0;
        while (tracker.pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_data = v;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.limit = v;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function t_table_cmd noise_cmd(logic [2:0] op);
        t_table_cmd c;
        c.command = op;
        c.ref_dynamic = 1'($urandom);
        c.index = 16'($urandom);
        c.name_len = 16'($urandom);
        c.value_len = 16'($urandom);
        c.new_capacity = 16'($urandom);
        c.encoded_count = 16'($urandom);
        c.ack_count = $urandom;
        return c;
    endfunction

    // Encoding of a required count near the current insert count.
    function logic [15:0] encode_near(int shift);
        longint unsigned max_ent, req;
        max_ent = tracker.limit / ENTRY_OVERHEAD;
        if (max_ent == 0) return 16'd0;
        req = longint'(tracker.inserts_total()) + shift;
        if (req == 0) return 16'd0;
        return 16'((req % (2 * max_ent)) + 1);
    endfunction

    // A random command, mostly well-formed against the current table.
    function t_table_cmd random_cmd();
        t_table_cmd c;
        int pick;
        pick = $urandom_range(0, 99);
        c = noise_cmd(3'($urandom_range(0, 7)));
        if (pick < 10) begin
            c.command = CMD_SET_CAP;
            if ($urandom_range(0, 5) != 0)
                c.new_capacity = 16'($urandom_range(0, tracker.limit));
        end else if (pick < 30) begin
            c.command = CMD_NAME_REF;
            if ($urandom_range(0, 7) != 0) begin
                c.index = c.ref_dynamic ? 16'($urandom_range(0, tracker.entry_count))
                                        : 16'($urandom_range(0, STATIC_ENTRIES));
                c.value_len = 16'($urandom_range(0, 200));
            end
        end else if (pick < 55) begin
            c.command = CMD_LITERAL;
            if ($urandom_range(0, 7) != 0) begin
                c.name_len = 16'($urandom_range(0, 40));
                c.value_len = 16'($urandom_range(0, 300));
            end
        end else if (pick < 68) begin
            c.command = CMD_DUP;
            if ($urandom_range(0, 7) != 0)
                c.index = 16'($urandom_range(0, tracker.entry_count));
        end else if (pick < 83) begin
            c.command = CMD_DECODE;
            if ($urandom_range(0, 5) != 0)
                c.encoded_count = encode_near(int'($urandom_range(0, 4)) - 2);
        end else if (pick < 91) begin
            c.command = CMD_ACK;
            if ($urandom_range(0, 5) != 0)
                c.ack_count = tracker.inserts_total() - $urandom_range(0, 3);
        end else if (pick < 97) begin
            c.command = CMD_FLUSH;
        end
        return c;
    endfunction

    // Receiving side: random stall before each result, then check it.
    initial begin
        int hold;
        i_stall = 1'b1;
        @(posedge i_rst_n);
        forever begin
            hold = $urandom_range(0, max_gap);
            repeat (hold) begin
                @(negedge i_clk);
                i_stall = 1'b1;
                @(posedge i_clk);
            end
            @(negedge i_clk);
            i_stall = 1'b0;
            do @(posedge i_clk); while (!o_valid);
            tracker.check_result('{o_status, o_abs_index, o_source_slot, o_new_slot,
                                   o_evicted, o_required_count, o_increment,
                                   o_total_inserted, o_used_size});
        end
    end

    // Main sequence: reset, directed commands, then random phases over several limits.
    initial begin
        t_table_cmd c;
        logic [LIMIT_W-1:0] limits [6];
        tracker = new();
        max_gap = 3;
        limits = '{15'd0, 15'd4096, 15'd31, 15'd96, 15'd1000, 15'd16384};
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        c = noise_cmd(CMD_ACK);
        {i_command, i_ref_dynamic, i_index, i_name_len} = '0;
        {i_value_len, i_new_capacity, i_encoded_count, i_ack_count} = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        write_limit(15'd16384);

        // Directed part: field extremes, every command, each error path.
        c = noise_cmd(CMD_SET_CAP); c.new_capacity = 16'd16385; send_command(c);
        c.new_capacity = 16'hFFFF; send_command(c);
        c.new_capacity = 16'd16384; send_command(c);
        c = noise_cmd(CMD_LITERAL); c.name_len = 16'd0; c.value_len = 16'd0; send_command(c);
        c.name_len = 16'hFFFF; c.value_len = 16'hFFFF; send_command(c);
        c = noise_cmd(CMD_NAME_REF); c.ref_dynamic = 1'b0; c.index = 16'd0;
        c.value_len = 16'd5;
        send_command(c);
        c.index = 16'd98; send_command(c);
        c.index = 16'd99; send_command(c);
        c.index = 16'hFFFF; send_command(c);
        c.ref_dynamic = 1'b1; c.index = 16'd0; send_command(c);
        c.index = 16'd3; send_command(c);
        c.index = 16'd4; send_command(c);
        c = noise_cmd(CMD_DUP); c.index = 16'd0; send_command(c);
        c.index = 16'hFFFF; send_command(c);
        c = noise_cmd(CMD_DECODE); c.encoded_count = 16'd0; send_command(c);
        c.encoded_count = encode_near(0); send_command(c);
        c.encoded_count = encode_near(1); send_command(c);
        c.encoded_count = 16'hFFFF; send_command(c);
        c = noise_cmd(CMD_ACK); c.ack_count = 32'd3; send_command(c);
        c.ack_count = 32'd1; send_command(c);
        c = noise_cmd(CMD_FLUSH); send_command(c);
        send_command(c);
        c = noise_cmd(3'd7); send_command(c);
        c = noise_cmd(CMD_SET_CAP); c.new_capacity = 16'd64; send_command(c);
        c = noise_cmd(CMD_LITERAL); c.name_len = 16'd20; c.value_len = 16'd20;
        send_command(c);

        // Random phases; one phase runs with neither side idling.
        foreach (limits[p]) begin
            write_limit(limits[p]);
            max_gap = (p == 2) ? 0 : 3;
            c = noise_cmd(CMD_SET_CAP);
            c.new_capacity = 16'($urandom_range(0, limits[p]));
            send_command(c);
            repeat (280) send_command(random_cmd());
        end
        max_gap = 3;

        @(negedge i_clk);
        i_valid = 1'b0;
        while (tracker.pending_results.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (tracker.errors == 0) begin
            $display("qpack_dynamic_table_bookkeeping: match");
        end else begin
            $display("qpack_dynamic_table_bookkeeping: mismatch");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #50ms;
        $display("qpack_dynamic_table_bookkeeping: mismatch");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/qdt_pkg.sv
rtl/core/qdt_ram.sv
rtl/core/qdt_rem.sv
rtl/core/qpack_dynamic_table_bookkeeping.sv
rtl/core/qdt_checker.sv
tb/sv/qpack_dynamic_table_bookkeeping_test.sv
